// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HKVT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HKVT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/hkvt_pkg.sv =====
// Types, codes and defaults shared by the hashed key/value table files.
package hkvt_pkg;

  localparam int KEY_W       = 31;
  localparam int VAL_W       = 64;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 3;
  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_DELETE = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = FUNC_W'(2);

  localparam logic [STAT_W-1:0] STAT_INSERTED = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_UPDATED  = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_DELETED  = STAT_W'(2);
  localparam logic [STAT_W-1:0] STAT_FOUND    = STAT_W'(3);
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = STAT_W'(4);
  localparam logic [STAT_W-1:0] STAT_FULL     = STAT_W'(5);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_BASE,
    S_ROW,
    S_READ,
    S_CMP,
    S_ACT
  } hkvt_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  name_value;
    logic [VAL_W-1:0]  class_value;
  } hkvt_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [VAL_W-1:0]  name_out;
    logic [VAL_W-1:0]  class_out;
  } hkvt_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] name_word;
    logic [VAL_W-1:0] class_word;
  } hkvt_entry_t;

endpackage

// ===== hdl/hashed_key_value_table_top.sv =====
// Top level of the hashed key/value table with set-associative buckets.
// Each item passes the key-modulo unit and a valid-row read, then an entry read and
//   key compare per way scanned, then the action step; a hit stops the scan early.
// Items are handled one at a time; the next item can be taken in the strobe cycle.
//   Results cannot be stalled by the receiver.
// Reset: clears control at once, then clears the valid bits of every bucket row, busy high.
module hashed_key_value_table_top #(
  parameter int BUCKETS = hkvt_pkg::BUCKETS_DEF,
  parameter int WAYS    = hkvt_pkg::WAYS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  hkvt_pkg::hkvt_req_t req_i,
  output logic                done_o,
  output hkvt_pkg::hkvt_rsp_t rsp_o
);

  localparam int DEPTH = BUCKETS * WAYS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BUCKETS);
  localparam int WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = $bits(hkvt_pkg::hkvt_entry_t);

  localparam logic [BW-1:0]   CLR_LAST = BW'(BUCKETS - 1);
  localparam logic [WIW-1:0]  WAY_LAST = WIW'(WAYS - 1);
  localparam logic [WAYS-1:0] ONE_WAY  = WAYS'(1);

  // Sequencer and per-item working registers.
  hkvt_pkg::hkvt_state_e state_q, state_d;
  hkvt_pkg::hkvt_req_t   req_q, req_d;
  hkvt_pkg::hkvt_entry_t hit_q, hit_d;
  hkvt_pkg::hkvt_rsp_t   rsp_q, rsp_d;
  logic                  done_q, done_d;
  logic [BW-1:0]         clr_q, clr_d;
  logic [BW-1:0]         bucket_q, bucket_d;
  logic [AW-1:0]         base_q, base_d;
  logic [WAYS-1:0]       row_q, row_d;
  logic [WIW-1:0]        way_q, way_d;
  logic                  match_q, match_d;
  logic [WIW-1:0]        match_way_q, match_way_d;
  logic                  free_q, free_d;
  logic [WIW-1:0]        free_way_q, free_way_d;

  // Shared key compare on the entry just read back.
  hkvt_pkg::hkvt_entry_t rd_entry;
  logic                  hit;

  // Modulo unit handshake.
  logic                  mod_start;
  logic                  mod_done;
  logic [BW-1:0]         mod_bucket;

  // Valid-bit RAM: one row of WAYS bits per bucket.
  logic                  vld_we;
  logic [BW-1:0]         vld_waddr;
  logic [WAYS-1:0]       vld_wdata;
  logic [WAYS-1:0]       vld_rdata;

  // Entry RAM: key and both value words, way w of bucket b at b*WAYS+w.
  logic                  ent_we;
  logic [AW-1:0]         ent_waddr;
  hkvt_pkg::hkvt_entry_t ent_wdata;
  logic [AW-1:0]         ent_raddr;
  logic [ENT_W-1:0]      ent_rdata;

  hkvt_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .key_i    (req_i.key),
    .done_o   (mod_done),
    .bucket_o (mod_bucket)
  );

  hkvt_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .raddr_i (bucket_q),
    .rdata_o (vld_rdata)
  );

  hkvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign rd_entry  = hkvt_pkg::hkvt_entry_t'(ent_rdata);
  assign hit       = row_q[way_q] && (rd_entry.key == req_q.key);
  assign ent_raddr = base_q + AW'(way_q);
  assign ent_wdata = '{key: req_q.key, name_word: req_q.name_value,
                       class_word: req_q.class_value};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hkvt_pkg::S_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = hkvt_pkg::S_IDLE;
      end
      hkvt_pkg::S_IDLE: begin
        if (start) state_d = hkvt_pkg::S_HASH;
      end
      hkvt_pkg::S_HASH: begin
        if (mod_done) state_d = hkvt_pkg::S_BASE;
      end
      hkvt_pkg::S_BASE: state_d = hkvt_pkg::S_ROW;
      hkvt_pkg::S_ROW:  state_d = hkvt_pkg::S_READ;
      hkvt_pkg::S_READ: state_d = hkvt_pkg::S_CMP;
      hkvt_pkg::S_CMP: begin
        // Stop on a hit: keys are unique among valid ways of a bucket.
        if (hit || (way_q == WAY_LAST)) begin
          state_d = hkvt_pkg::S_ACT;
        end else begin
          state_d = hkvt_pkg::S_READ;
        end
      end
      hkvt_pkg::S_ACT:  state_d = hkvt_pkg::S_IDLE;
      default:          state_d = hkvt_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result.
  always_comb begin
    req_d       = req_q;
    hit_d       = hit_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    clr_d       = clr_q;
    bucket_d    = bucket_q;
    base_d      = base_q;
    row_d       = row_q;
    way_d       = way_q;
    match_d     = match_q;
    match_way_d = match_way_q;
    free_d      = free_q;
    free_way_d  = free_way_q;
    mod_start   = 1'b0;
    vld_we      = 1'b0;
    vld_waddr   = bucket_q;
    vld_wdata   = row_q;
    ent_we      = 1'b0;
    ent_waddr   = base_q + AW'(match_way_q);
    case (state_q)
      hkvt_pkg::S_CLEAR: begin
        // Sweep one bucket row of valid bits per cycle.
        vld_we    = 1'b1;
        vld_waddr = clr_q;
        vld_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      hkvt_pkg::S_IDLE: begin
        if (start) begin
          req_d     = req_i;
          mod_start = 1'b1;
        end
      end
      hkvt_pkg::S_HASH: begin
        if (mod_done) bucket_d = mod_bucket;
      end
      hkvt_pkg::S_BASE: begin
        // Valid row read is issued here through bucket_q.
        base_d  = AW'(bucket_q * WAYS);
        way_d   = '0;
        match_d = 1'b0;
        free_d  = 1'b0;
      end
      hkvt_pkg::S_ROW: begin
        row_d = vld_rdata;
      end
      hkvt_pkg::S_READ: begin
        // Entry read of the current way goes out through ent_raddr.
      end
      hkvt_pkg::S_CMP: begin
        if (hit) begin
          match_d     = 1'b1;
          match_way_d = way_q;
          hit_d       = rd_entry;
        end else if (!row_q[way_q] && !free_q) begin
          free_d     = 1'b1;
          free_way_d = way_q;
        end
        way_d = way_q + 1'b1;
      end
      hkvt_pkg::S_ACT: begin
        done_d          = 1'b1;
        rsp_d.status    = hkvt_pkg::STAT_NOTFOUND;
        rsp_d.found     = 1'b0;
        rsp_d.name_out  = '0;
        rsp_d.class_out = '0;
        case (req_q.func)
          hkvt_pkg::FUNC_INSERT: begin
            if (match_q) begin
              ent_we       = 1'b1;
              rsp_d.status = hkvt_pkg::STAT_UPDATED;
            end else if (free_q) begin
              ent_we       = 1'b1;
              ent_waddr    = base_q + AW'(free_way_q);
              vld_we       = 1'b1;
              vld_wdata    = row_q | (ONE_WAY << free_way_q);
              rsp_d.status = hkvt_pkg::STAT_INSERTED;
            end else begin
              rsp_d.status = hkvt_pkg::STAT_FULL;
            end
          end
          hkvt_pkg::FUNC_DELETE: begin
            if (match_q) begin
              vld_we       = 1'b1;
              vld_wdata    = row_q & ~(ONE_WAY << match_way_q);
              rsp_d.status = hkvt_pkg::STAT_DELETED;
            end
          end
          hkvt_pkg::FUNC_LOOKUP: begin
            if (match_q) begin
              rsp_d.status    = hkvt_pkg::STAT_FOUND;
              rsp_d.found     = 1'b1;
              rsp_d.name_out  = hit_q.name_word;
              rsp_d.class_out = hit_q.class_word;
            end
          end
          default: begin
            // Unused operation code: drop it, report not found.
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hkvt_pkg::S_CLEAR;
      done_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    hit_q       <= hit_d;
    rsp_q       <= rsp_d;
    bucket_q    <= bucket_d;
    base_q      <= base_d;
    row_q       <= row_d;
    way_q       <= way_d;
    match_q     <= match_d;
    match_way_q <= match_way_d;
    free_q      <= free_d;
    free_way_q  <= free_way_d;
  end

  assign busy   = (state_q != hkvt_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== hdl/hkvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hkvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hkvt_mod.sv =====
// Key modulo the bucket count by reciprocal multiplication: quotient, then remainder.
module hkvt_mod #(
  parameter int BUCKETS = hkvt_pkg::BUCKETS_DEF,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hkvt_pkg::KEY_W-1:0] key_i,
  output logic                     done_o,
  output logic [BW-1:0]            bucket_o
);

  // Quotient is floor(key * RECIP / 2**SH) with RECIP = ceil(2**SH / BUCKETS);
  // the rounding error of RECIP stays below one part in BUCKETS, so it is exact
  // for every key.
  localparam int KW = hkvt_pkg::KEY_W;
  localparam int RW = KW + 1;
  localparam int SH = KW + BW;
  localparam int PW = 2 * KW + 1;
  localparam int QW = PW - SH;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  logic          step_q;
  logic          done_q;
  logic [KW-1:0] key_q;
  logic [QW-1:0] quo_q;
  logic [BW-1:0] rem_q;
  logic [PW-1:0] prod;
  logic [KW-1:0] back;
  logic [KW-1:0] rem_full;

  // The quotient is registered from the incoming key, then the remainder from the held key.
  assign prod     = PW'(key_i) * PW'(RECIP);
  assign back     = KW'(quo_q) * KW'(BUCKETS);
  assign rem_full = key_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= start_i;
      done_q <= step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      quo_q <= prod[PW-1:SH];
    end
    if (step_q) begin
      rem_q <= rem_full[BW-1:0];
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ===== hdl/hkvt_checker.sv =====
// Port-level checker for the hashed key/value table, bound to the top level.
`include "assert_macros.svh"

module hkvt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input hkvt_pkg::hkvt_rsp_t rsp_o
);

  `HKVT_ASSERT_IMP(a_done_when_idle, clk_i, rst_ni, done_o, !busy)
  `HKVT_ASSERT_NXT(a_start_sets_busy, clk_i, rst_ni, start && !busy, busy)
  `HKVT_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `HKVT_ASSERT_IMP(a_hit_status, clk_i, rst_ni, done_o && rsp_o.found, rsp_o.status == hkvt_pkg::STAT_FOUND)
  `HKVT_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_o && !rsp_o.found, rsp_o.name_out == '0 && rsp_o.class_out == '0)

endmodule

bind hashed_key_value_table_top hkvt_checker u_hkvt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
